FILE: sv/sha_pkg.sv
package sha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_OFFSET  = 56;
    localparam int ROUNDS      = 64;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       has_byte;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
        logic [31:0] digest_word5;
        logic [31:0] digest_word6;
        logic [31:0] digest_word7;
    } sha_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD,
        ST_FINAL,
        ST_OUT
    } sha_state_t;

    typedef struct packed {
        logic       buf_wr;
        logic [5:0] buf_addr;
        logic [7:0] buf_data;
        logic       cnt_inc;
        logic       cnt_clr;
        logic       start;
        logic       round;
        logic       finish;
        logic       chain_init;
        logic       load_out;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
        logic       last_round;
    } sha_stat_t;

    localparam logic [31:0] INIT_CHAIN [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: sv/sha_ctrl.sv
module sha_ctrl
    import sha_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sha_in_t   s_data,
    output logic      m_valid,
    input  logic      m_ready,
    input  sha_stat_t stat,
    output sha_cmd_t  cmd
);

    sha_state_t state_reg, state_next;
    logic       eom_reg, eom_next;
    logic       two_reg, two_next;
    logic       pad_reg, pad_next;
    logic [5:0] ppos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            eom_reg   <= 1'b0;
            two_reg   <= 1'b0;
            pad_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            eom_reg   <= eom_next;
            two_reg   <= two_next;
            pad_reg   <= pad_next;
        end
    end

    // buffer position: byte write address, or pad position in ST_PAD
    assign ppos = stat.pos;

    always_comb begin
        state_next = state_reg;
        eom_next   = eom_reg;
        two_next   = two_reg;
        pad_next   = pad_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.has_byte) begin
                        cmd.buf_wr   = 1'b1;
                        cmd.buf_addr = ppos;
                        cmd.buf_data = s_data.message_byte;
                        cmd.cnt_inc  = 1'b1;
                        eom_next     = s_data.end_of_message;
                        if (ppos == 6'd63) begin
                            cmd.start  = 1'b1;
                            state_next = ST_ROUND;
                        end else if (s_data.end_of_message) begin
                            state_next = ST_PAD;
                        end
                    end else if (s_data.end_of_message) begin
                        eom_next   = 1'b1;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // datapath builds the padded block from the byte count
                two_next   = !pad_reg && (ppos >= 6'd56);
                pad_next   = 1'b1;
                cmd.start  = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (stat.last_round) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                cmd.finish = 1'b1;
                if (two_reg) begin
                    two_next   = 1'b0;
                    state_next = ST_PAD;
                end else if (eom_reg && !pad_reg) begin
                    state_next = ST_PAD;
                end else if (eom_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.load_out   = 1'b1;
                    cmd.chain_init = 1'b1;
                    cmd.cnt_clr    = 1'b1;
                    eom_next       = 1'b0;
                    pad_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: sv/sha_dp.sv
module sha_dp
    import sha_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  sha_cmd_t  cmd,
    input  logic      in_pad,
    output sha_stat_t stat,
    output sha_out_t  m_data
);

    logic [60:0] cnt_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  t_reg;
    logic        pad_done_reg;

    logic [31:0] w_cur, s0, s1, t1, t2, wnew;
    logic [63:0] bits;

    assign bits = {cnt_reg, 3'b000};
    assign stat.pos = cnt_reg[5:0];
    assign stat.last_round = (t_reg == 6'd63);

    // w_reg holds the block bytes while idle, then acts as a shifting
    // schedule window; w_reg[0] is the oldest word
    assign s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wnew = s1 + w_reg[9] + s0 + w_reg[0];
    assign w_cur = (t_reg < 6'd16) ? w_reg[t_reg[3:0]] : wnew;

    assign t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[t_reg] + w_cur;
    assign t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            pad_done_reg <= 1'b0;
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_CHAIN[i];
        end else begin
            if (cmd.cnt_inc) cnt_reg <= cnt_reg + 61'd1;
            if (cmd.cnt_clr) begin
                cnt_reg      <= '0;
                pad_done_reg <= 1'b0;
            end
            if (cmd.chain_init) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= INIT_CHAIN[i];
            end
            if (cmd.finish) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (cmd.start && in_pad) begin
                pad_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.buf_wr) begin
            w_reg[cmd.buf_addr[5:2]][8 * (3 - cmd.buf_addr[1:0]) +: 8] <= cmd.buf_data;
        end
        if (cmd.start) begin
            t_reg <= 6'd0;
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
            if (in_pad) begin
                for (int j = 0; j < 16; j++) begin
                    for (int b = 0; b < 4; b++) begin
                        logic [5:0] a;
                        logic [7:0] d;
                        a = 6'(4 * j + b);
                        d = w_reg[j][31 - 8 * b -: 8];
                        if (pad_done_reg) begin
                            // second padding block: zeros then length
                            d = (a >= 6'd56) ? bits[8 * (63 - a) +: 8] : 8'h00;
                        end else if (a == cnt_reg[5:0]) begin
                            d = PAD_MARK;
                        end else if (a > cnt_reg[5:0]) begin
                            d = (cnt_reg[5:0] < 6'd56 && a >= 6'd56)
                              ? bits[8 * (63 - a) +: 8] : 8'h00;
                        end
                        w_reg[j][31 - 8 * b -: 8] <= d;
                    end
                end
            end
        end else if (cmd.round) begin
            t_reg <= t_reg + 6'd1;
            if (t_reg >= 6'd16) begin
                for (int j = 0; j < 15; j++) w_reg[j] <= w_reg[j + 1];
                w_reg[15] <= wnew;
            end
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign m_data = {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                     h_reg[4], h_reg[5], h_reg[6], h_reg[7]};

    logic unused;
    assign unused = cmd.load_out;

endmodule

FILE: sv/sha256_stream_hash_core.sv
// Streaming SHA-256. One request per message byte; a byte that completes a
// 64-byte block starts a 64-round compression (one round per cycle, then a
// chain update), during which no request is taken. A request with
// end_of_message pads the message in one or two further blocks (load, 64
// rounds, chain update each) and then presents the eight digest words; after
// the digest is taken the chain and length return to their initial values.
// Throughput is set by the single round unit.
module sha256_stream_hash_core
    import sha_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sha_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sha_out_t m_data
);

    sha_cmd_t  cmd;
    sha_stat_t stat;
    logic      in_pad;

    sha_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .stat, .cmd
    );

    // padding blocks are started only from the pad state; the datapath sees
    // that as a start with no byte write in the same cycle
    assign in_pad = cmd.start && !cmd.buf_wr;

    sha_dp u_dp (
        .aclk, .aresetn, .cmd, .in_pad, .stat, .m_data
    );

endmodule

FILE: sv/sha_chk.sv
module sha_chk
    import sha_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input sha_out_t m_data
);

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken while digest pending");

    a_after: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("digest repeated");

endmodule

bind sha256_stream_hash_core sha_chk u_chk (.*);
